// ===== sv/didt_pkg.sv =====
// ----------------------------------------------------------------------------
// didt_pkg
// Shared types and constants of the display idle dim/off timer.
// ----------------------------------------------------------------------------
package didt_pkg;

	// field widths
	localparam int NOW_W      = 48;
	localparam int TIMEOUT_W  = 32;
	localparam int STATE_W    = 2;
	localparam int TIME_BITS_DEF = 48;

	// configuration port
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DIM_TIMEOUT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_TIMEOUT = 1'b1;

	// register reset values
	localparam logic [TIMEOUT_W-1:0] DIM_TIMEOUT_RST = 32'd30000;
	localparam logic [TIMEOUT_W-1:0] OFF_TIMEOUT_RST = 32'd60000;

	// display states
	typedef enum logic [STATE_W-1:0] {
		MODE_AWAKE  = 2'd0,
		MODE_DIMMED = 2'd1,
		MODE_OFF    = 2'd2
	} mode_t;

	// timeout settings handed to the update logic
	typedef struct packed {
		logic [TIMEOUT_W-1:0] dim_timeout;
		logic [TIMEOUT_W-1:0] off_timeout;
	} cfg_t;

	// one result word
	typedef struct packed {
		mode_t display_state;
		logic  mode_changed;
		logic  consume_event;
	} result_t;

endpackage

// ===== sv/didt_if.sv =====
// ----------------------------------------------------------------------------
// didt_if
// Valid/ready channels for update words and status words.
// ----------------------------------------------------------------------------
interface didt_update_if;
	logic                       valid;
	logic                       ready;
	logic [didt_pkg::NOW_W-1:0] now_ms;
	logic                       btn_held;
	logic                       btn_press;

	modport source (output valid, now_ms, btn_held, btn_press, input ready);
	modport sink   (input valid, now_ms, btn_held, btn_press, output ready);
endinterface

interface didt_status_if;
	logic                         valid;
	logic                         ready;
	logic [didt_pkg::STATE_W-1:0] display_state;
	logic                         mode_changed;
	logic                         consume_event;

	modport source (output valid, display_state, mode_changed, consume_event, input ready);
	modport sink   (input valid, display_state, mode_changed, consume_event, output ready);
endinterface

// ===== sv/didt_cfg.sv =====
// ----------------------------------------------------------------------------
// didt_cfg
// APB register file holding the dim and off timeouts.
// ----------------------------------------------------------------------------
module didt_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [didt_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [didt_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [didt_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                                pready,
	output didt_pkg::cfg_t                      cfg
);

	logic [didt_pkg::TIMEOUT_W-1:0] dim_q;
	logic [didt_pkg::TIMEOUT_W-1:0] off_q;
	logic [didt_pkg::CFG_IDX_W-1:0] idx;
	logic                           wr_en;

	// word address decode
	assign idx    = paddr[didt_pkg::CFG_ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= didt_pkg::DIM_TIMEOUT_RST;
			off_q <= didt_pkg::OFF_TIMEOUT_RST;
		end else if (wr_en) begin
			unique case (idx)
				didt_pkg::REG_DIM_TIMEOUT: dim_q <= pwdata;
				didt_pkg::REG_OFF_TIMEOUT: off_q <= pwdata;
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (idx)
			didt_pkg::REG_DIM_TIMEOUT: prdata = dim_q;
			didt_pkg::REG_OFF_TIMEOUT: prdata = off_q;
			default:                   prdata = '0;
		endcase
	end

	assign cfg.dim_timeout = dim_q;
	assign cfg.off_timeout = off_q;

endmodule

// ===== sv/didt_update.sv =====
// ----------------------------------------------------------------------------
// didt_update
// Display state, activity timestamp and swallow flag, with the per-word
// decision logic that advances them.
// ----------------------------------------------------------------------------
module didt_update #(
	parameter int TIME_BITS = didt_pkg::TIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic [TIME_BITS-1:0] now,
	input  logic                 held,
	input  logic                 ev,
	input  didt_pkg::cfg_t       cfg,
	output didt_pkg::result_t    result
);

	didt_pkg::mode_t      mode_q;
	logic [TIME_BITS-1:0] last_q;
	logic                 swallow_q;

	didt_pkg::mode_t      mode_d;
	logic [TIME_BITS-1:0] last_d;
	logic                 swallow_d;
	logic                 changed;
	logic                 consume;

	logic [TIME_BITS-1:0]            base;
	logic [TIME_BITS-1:0]            idle;
	logic                            backwards;
	logic [didt_pkg::TIMEOUT_W-1:0]  off_eff;
	logic                            past_off;
	logic                            past_dim;
	didt_pkg::mode_t                 timed_mode;

	// idle time against both thresholds
	assign base      = ev ? now : last_q;
	assign backwards = now < base;
	assign idle      = now - base;
	assign off_eff   = (cfg.off_timeout < cfg.dim_timeout) ? cfg.dim_timeout
	                                                       : cfg.off_timeout;
	assign past_off  = idle >= TIME_BITS'(off_eff);
	assign past_dim  = idle >= TIME_BITS'(cfg.dim_timeout);

	always_comb begin
		if (past_off) begin
			timed_mode = didt_pkg::MODE_OFF;
		end else if (past_dim) begin
			timed_mode = didt_pkg::MODE_DIMMED;
		end else begin
			timed_mode = didt_pkg::MODE_AWAKE;
		end
	end

	// next state
	always_comb begin
		mode_d    = mode_q;
		last_d    = last_q;
		swallow_d = swallow_q;
		changed   = 1'b0;
		consume   = 1'b0;
		if (mode_q != didt_pkg::MODE_AWAKE && (held || ev)) begin
			// wake by button
			mode_d    = didt_pkg::MODE_AWAKE;
			last_d    = now;
			swallow_d = held;
			changed   = 1'b1;
			consume   = ev;
		end else if (swallow_q) begin
			last_d  = now;
			consume = ev;
			if (!held) begin
				swallow_d = 1'b0;
			end
		end else if (held) begin
			last_d = now;
		end else if (backwards) begin
			last_d = now;
		end else begin
			last_d = base;
			if (timed_mode != mode_q) begin
				mode_d  = timed_mode;
				changed = 1'b1;
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= didt_pkg::MODE_AWAKE;
			last_q    <= '0;
			swallow_q <= 1'b0;
		end else if (fire) begin
			mode_q    <= mode_d;
			last_q    <= last_d;
			swallow_q <= swallow_d;
		end
	end

	assign result.display_state = mode_d;
	assign result.mode_changed  = changed;
	assign result.consume_event = consume;

endmodule

// ===== sv/display_idle_dim_off_timer_core.sv =====
// ----------------------------------------------------------------------------
// display_idle_dim_off_timer_core
// Display inactivity timer: dims, then switches off, and wakes on a button.
// ----------------------------------------------------------------------------
// Usage:
//   update  - valid/ready channel of update words (now_ms, btn_held,
//             btn_press); one word per display tick.
//   status  - valid/ready channel of status words (display_state,
//             mode_changed, consume_event); exactly one per update word,
//             in order.
//   APB     - dim_timeout at 0x0, off_timeout at 0x4; write only while no
//             word is in flight.
// An accepted update word is held in the input register, then the decision
// logic loads the status register, which presents it as a status word.
// Throughput is one word per cycle while status words are taken; the loop
// through the state registers is a single subtract and the compares against
// the base and both thresholds.
// A full status register that is not taken stalls the input register, and
// update.ready drops only when both hold a word.
// Reset puts the display awake, the activity timestamp at zero, clears the
// swallow flag and loads the default timeouts.
// ----------------------------------------------------------------------------
module display_idle_dim_off_timer_core #(
	parameter int TIME_BITS = didt_pkg::TIME_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	didt_update_if.sink                       update,
	didt_status_if.source                     status,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [didt_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [didt_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [didt_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                              pready
);

	didt_pkg::cfg_t             cfg;
	didt_pkg::result_t          result;

	logic                       valid_s1;
	logic [didt_pkg::NOW_W-1:0] now_s1;
	logic                       held_s1;
	logic                       ev_s1;
	logic                       advance;
	logic [TIME_BITS-1:0]       now_t;

	logic                       out_valid_q;
	didt_pkg::result_t          out_q;

	// configuration registers
	didt_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// handshake between the two register stages
	assign advance      = valid_s1 && (!out_valid_q || status.ready);
	assign update.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (update.ready) begin
			valid_s1 <= update.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (update.valid && update.ready) begin
			now_s1  <= update.now_ms;
			held_s1 <= update.btn_held;
			ev_s1   <= update.btn_press;
		end
	end

	// time in the counter width
	generate
		if (TIME_BITS <= didt_pkg::NOW_W) begin : g_trunc
			assign now_t = now_s1[TIME_BITS-1:0];
		end else begin : g_ext
			assign now_t = {{(TIME_BITS - didt_pkg::NOW_W){1'b0}}, now_s1};
		end
	endgenerate

	// state and decision logic
	didt_update #(
		.TIME_BITS (TIME_BITS)
	) u_update (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.now    (now_t),
		.held   (held_s1),
		.ev     (ev_s1),
		.cfg    (cfg),
		.result (result)
	);

	// status register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (status.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign status.valid         = out_valid_q;
	assign status.display_state = out_q.display_state;
	assign status.mode_changed  = out_q.mode_changed;
	assign status.consume_event = out_q.consume_event;

endmodule

// ===== sv/didt_checker.sv =====
// ----------------------------------------------------------------------------
// didt_checker
// Port-level checks of the display idle timer, bound to the top level.
// ----------------------------------------------------------------------------
module didt_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         up_valid,
	input logic                         up_ready,
	input logic                         st_valid,
	input logic                         st_ready,
	input logic [didt_pkg::STATE_W-1:0] st_state,
	input logic                         st_changed,
	input logic                         st_consume
);

	// a pending status word holds until taken
	a_status_hold: assert property (@(posedge clk) disable iff (!arst_n)
		st_valid && !st_ready |=> st_valid)
		else $error("status word dropped while stalled");

	a_status_stable: assert property (@(posedge clk) disable iff (!arst_n)
		st_valid && !st_ready |=> $stable(st_state) && $stable(st_changed)
			&& $stable(st_consume))
		else $error("status word changed while stalled");

	// a fresh status word follows an accepted update word, through the input and status registers
	a_status_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(st_valid) |-> $past(up_valid && up_ready, 2))
		else $error("status word without a matching update word");

	// a swallowed event only happens with the display awake
	a_consume_awake: assert property (@(posedge clk) disable iff (!arst_n)
		st_valid && st_consume |-> st_state == didt_pkg::MODE_AWAKE)
		else $error("event swallowed while display not awake");

endmodule

bind display_idle_dim_off_timer_core didt_checker u_didt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.up_valid   (update.valid),
	.up_ready   (update.ready),
	.st_valid   (status.valid),
	.st_ready   (status.ready),
	.st_state   (status.display_state),
	.st_changed (status.mode_changed),
	.st_consume (status.consume_event)
);
